// File: rtl/core/cylinder_wind_field_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cylinder wind field block
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_WIND_FIELD_TOP_DEFINES_SVH
`define CYLINDER_WIND_FIELD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CWF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CWF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CWF_ASSERT_IMPLY(label, ante, cons)
`define CWF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/cwf_pkg.sv
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared widths, register indexes and pipeline payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cwf_pkg;
    localparam int DW = 86;          // signed width of the root remainders
    localparam int R2W = 48;         // width of y*y + z*z
    localparam int NW = 16;          // bits of a vortex component magnitude
    localparam logic [22:0] MIN_EXTENT = 23'd410;

    localparam logic [2:0] REG_LENGTH  = 3'd0;
    localparam logic [2:0] REG_RADIUS  = 3'd1;
    localparam logic [2:0] REG_MODE    = 3'd2;
    localparam logic [2:0] REG_SPEED   = 3'd3;
    localparam logic [2:0] REG_REVERSE = 3'd4;

    typedef struct packed {
        logic in_vol;
        logic axis;
        logic z_pos;
        logic y_neg;
    } side_t;

    typedef struct packed {
        logic signed [DW-1:0] d_y;
        logic signed [DW-1:0] m_y;
        logic signed [DW-1:0] d_z;
        logic signed [DW-1:0] m_z;
        logic [R2W-1:0]       r2;
        logic [NW-1:0]        n_y;
        logic [NW-1:0]        n_z;
        side_t                side;
    } iter_t;
endpackage
`default_nettype wire

// File: rtl/core/cwf_front.sv
// ----------------------------------------------------------------------------
// cwf_front
// Four stages: bounds and magnitudes, squares, radial test and partial
// products, then the starting remainders of the root search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cwf_front
    import cwf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [22:0]        cyl_length,
    input  wire logic [22:0]        cyl_radius,
    input  wire logic [15:0]        wind_speed,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] pos_x,
    input  wire logic signed [23:0] pos_y,
    input  wire logic signed [23:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output iter_t                   out_item
);
    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] rdy;

    // stage 1
    logic        inx1_reg, zpos1_reg, yneg1_reg;
    logic [23:0] ay1_reg, az1_reg;
    // stage 2
    logic        inx2_reg, zpos2_reg, yneg2_reg;
    logic [47:0] ay2_reg, az2_reg;
    logic [31:0] w2_reg;
    logic [45:0] rad2_reg;
    // stage 3
    logic           zpos3_reg, yneg3_reg, inside3_reg;
    logic [R2W-1:0] r2_3_reg;
    logic [55:0]    ppy_lo_reg, ppy_hi_reg, ppz_lo_reg, ppz_hi_reg;
    // stage 4
    iter_t item_reg;

    logic [22:0]        lenc;
    logic [22:0]        radc;
    logic signed [25:0] x2;
    logic signed [25:0] lim;
    logic [R2W-1:0]     r2_sum;
    logic [DW-1:0]      a2y, a2z;
    logic signed [DW-1:0] r2_ext;

    assign rdy[3] = !v_reg[3] || out_ready;
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];
    assign out_valid = v_reg[3];
    assign out_item = item_reg;

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
        begin
            v_next[0] = in_valid;
        end
        if (rdy[1])
        begin
            v_next[1] = v_reg[0];
        end
        if (rdy[2])
        begin
            v_next[2] = v_reg[1];
        end
        if (rdy[3])
        begin
            v_next[3] = v_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign lenc = (cyl_length < MIN_EXTENT) ? MIN_EXTENT : cyl_length;
    assign radc = (cyl_radius < MIN_EXTENT) ? MIN_EXTENT : cyl_radius;
    assign x2 = {pos_x[23], pos_x, 1'b0};
    assign lim = $signed({3'b000, lenc});
    assign r2_sum = ay2_reg + az2_reg;
    assign a2y = {{(DW-82){1'b0}}, ({ppy_hi_reg, 24'd0} + {24'd0, ppy_lo_reg}), 2'b00};
    assign a2z = {{(DW-82){1'b0}}, ({ppz_hi_reg, 24'd0} + {24'd0, ppz_lo_reg}), 2'b00};
    assign r2_ext = $signed({{(DW-R2W){1'b0}}, r2_3_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            inx1_reg  <= (x2 > -lim) && (x2 < lim);
            ay1_reg   <= pos_y[23] ? (~pos_y + 24'd1) : pos_y;
            az1_reg   <= pos_z[23] ? (~pos_z + 24'd1) : pos_z;
            zpos1_reg <= !pos_z[23] && (pos_z != 24'sd0);
            yneg1_reg <= pos_y[23];
        end
        if (rdy[1])
        begin
            inx2_reg  <= inx1_reg;
            zpos2_reg <= zpos1_reg;
            yneg2_reg <= yneg1_reg;
            ay2_reg   <= ay1_reg * ay1_reg;
            az2_reg   <= az1_reg * az1_reg;
            w2_reg    <= wind_speed * wind_speed;
            rad2_reg  <= radc * radc;
        end
        if (rdy[2])
        begin
            zpos3_reg   <= zpos2_reg;
            yneg3_reg   <= yneg2_reg;
            r2_3_reg    <= r2_sum;
            inside3_reg <= inx2_reg && (r2_sum < {2'b00, rad2_reg});
            // force_y scales by |z|, force_z by |y|
            ppy_lo_reg  <= w2_reg * az2_reg[23:0];
            ppy_hi_reg  <= w2_reg * az2_reg[47:24];
            ppz_lo_reg  <= w2_reg * ay2_reg[23:0];
            ppz_hi_reg  <= w2_reg * ay2_reg[47:24];
        end
        if (rdy[3])
        begin
            item_reg.d_y <= $signed(a2y) - r2_ext;
            item_reg.d_z <= $signed(a2z) - r2_ext;
            item_reg.m_y <= -r2_ext;
            item_reg.m_z <= -r2_ext;
            item_reg.r2  <= r2_3_reg;
            item_reg.n_y <= '0;
            item_reg.n_z <= '0;
            item_reg.side.in_vol <= inside3_reg;
            item_reg.side.axis   <= (r2_3_reg == '0);
            item_reg.side.z_pos  <= zpos3_reg;
            item_reg.side.y_neg  <= yneg3_reg;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/cwf_root_stage.sv
// ----------------------------------------------------------------------------
// cwf_root_stage
// One bit of the rounded quotient search for both vortex components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cwf_root_stage
    import cwf_pkg::*;
#(
    parameter int BIT = 15
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  iter_t     in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output iter_t     out_item
);
    logic  v_reg;
    iter_t item_reg;
    logic signed [DW-1:0] r2s;
    logic signed [DW-1:0] dn_y, dn_z;
    iter_t nx;

    assign in_ready = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_item = item_reg;
    assign r2s = $signed({{(DW-R2W){1'b0}}, in_item.r2});

    // trial: D - ((M << (BIT+2)) + (r2 << (2*BIT+2)))
    assign dn_y = in_item.d_y - ((in_item.m_y <<< (BIT + 2)) + (r2s <<< (2 * BIT + 2)));
    assign dn_z = in_item.d_z - ((in_item.m_z <<< (BIT + 2)) + (r2s <<< (2 * BIT + 2)));

    always_comb
    begin
        nx = in_item;
        if (!dn_y[DW-1])
        begin
            nx.d_y = dn_y;
            nx.m_y = in_item.m_y + (r2s <<< (BIT + 1));
            nx.n_y[BIT] = 1'b1;
        end
        if (!dn_z[DW-1])
        begin
            nx.d_z = dn_z;
            nx.m_z = in_item.m_z + (r2s <<< (BIT + 1));
            nx.n_z[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            item_reg <= nx;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/cylinder_wind_field_top.sv
// ----------------------------------------------------------------------------
// cylinder_wind_field_top
// Wind force of a cylinder volume lying along x, one point per clock while out_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the in channel (in_valid / in_ready, pos_x/y/z in signed
//   Q11.12 metres). Each point yields one item on the out channel
//   (out_valid / out_ready) carrying force_x/y/z in signed Q8.8 m/s and
//   inside_volume.
//   Depth: 21 register stages (four front stages, sixteen search stages,
//   one output register). Throughput: one item per cycle while out_ready
//   is high; the sixteen-stage bitwise search for the rounded vortex
//   magnitude sets the depth, one result bit per stage.
//   Write registers over the APB-style port only while no item is in flight;
//   the block does not enforce it. pready is always high, reads return the
//   stored values. Reset clears all valid bits and loads the register defaults.
//   When the receiver holds out_ready low, the output holds and each stage
//   fills its empty slots before in_ready drops, so nothing is lost or
//   repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cylinder_wind_field_top_defines.svh"
module cylinder_wind_field_top
    import cwf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] pos_x,
    input  wire logic signed [23:0] pos_y,
    input  wire logic signed [23:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [16:0]      force_x,
    output logic signed [16:0]      force_y,
    output logic signed [16:0]      force_z,
    output logic                    inside_volume
);
    // configuration registers
    logic [22:0] cyl_length_reg;
    logic [22:0] cyl_radius_reg;
    logic        flow_mode_reg;
    logic [15:0] wind_speed_reg;
    logic        reverse_flow_reg;
    logic [2:0]  reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_length_reg   <= 23'd20480;
            cyl_radius_reg   <= 23'd4096;
            flow_mode_reg    <= 1'b0;
            wind_speed_reg   <= 16'd2560;
            reverse_flow_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_LENGTH:  cyl_length_reg   <= pwdata[22:0];
                REG_RADIUS:  cyl_radius_reg   <= pwdata[22:0];
                REG_MODE:    flow_mode_reg    <= pwdata[0];
                REG_SPEED:   wind_speed_reg   <= pwdata[15:0];
                REG_REVERSE: reverse_flow_reg <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LENGTH:  prdata = {9'd0, cyl_length_reg};
            REG_RADIUS:  prdata = {9'd0, cyl_radius_reg};
            REG_MODE:    prdata = {31'd0, flow_mode_reg};
            REG_SPEED:   prdata = {16'd0, wind_speed_reg};
            REG_REVERSE: prdata = {31'd0, reverse_flow_reg};
            default:     prdata = '0;
        endcase
    end

    // front end: bounds, squares, starting remainders
    logic  chain_valid [0:NW];
    logic  chain_ready [0:NW];
    iter_t chain_item  [0:NW];

    cwf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cyl_length (cyl_length_reg),
        .cyl_radius (cyl_radius_reg),
        .wind_speed (wind_speed_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_item   (chain_item[0])
    );

    // search: one result bit per stage, most significant first
    for (genvar g = 0; g < NW; g++)
    begin : g_root
        cwf_root_stage #(
            .BIT (NW - 1 - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // output register
    logic               out_valid_reg;
    logic signed [16:0] fx_reg, fy_reg, fz_reg;
    logic               inside_reg;
    logic               take;
    logic [16:0]        w_ext;
    logic [16:0]        ny_ext, nz_ext;
    side_t              sd;

    assign take = !out_valid_reg || out_ready;
    assign chain_ready[NW] = take;
    assign sd = chain_item[NW].side;
    assign w_ext = {1'b0, wind_speed_reg};
    assign ny_ext = {1'b0, chain_item[NW].n_y};
    assign nz_ext = {1'b0, chain_item[NW].n_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= chain_valid[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            inside_reg <= sd.in_vol;
            fx_reg <= '0;
            fy_reg <= '0;
            fz_reg <= '0;
            if (sd.in_vol)
            begin
                if (!flow_mode_reg)
                begin
                    fx_reg <= reverse_flow_reg ? -$signed(w_ext) : $signed(w_ext);
                end
                else if (!sd.axis)
                begin
                    // drop the sign onto each rounded magnitude
                    fy_reg <= (sd.z_pos != reverse_flow_reg) ? -$signed(ny_ext)
                                                            : $signed(ny_ext);
                    fz_reg <= (sd.y_neg != reverse_flow_reg) ? -$signed(nz_ext)
                                                            : $signed(nz_ext);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign force_x = fx_reg;
    assign force_y = fy_reg;
    assign force_z = fz_reg;
    assign inside_volume = inside_reg;

    `CWF_ASSERT_IMPLY(a_outside_zero, out_valid && !inside_volume,
        force_x == 17'sd0 && force_y == 17'sd0 && force_z == 17'sd0)
    `CWF_ASSERT_IMPLY(a_vortex_no_x, out_valid && flow_mode_reg, force_x == 17'sd0)
    `CWF_ASSERT_IMPLY(a_empty_takes, !out_valid, in_ready)
    `CWF_ASSERT_NEXT(a_stall_holds_result, out_valid && !out_ready,
        out_valid && $stable(force_y) && $stable(force_z))
endmodule
`default_nettype wire

// File: test/wind_force_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Wind force checker
// Predicts the force of each point from the mirrored register file and
// compares every result item with the oldest expected force.
// ============================================================================
module wind_force_checker
    import cwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] pos_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [16:0] force_x,
    input  logic signed [16:0] force_y,
    input  logic signed [16:0] force_z,
    input  logic               inside_volume,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);
    typedef struct packed {
        logic signed [16:0] fx;
        logic signed [16:0] fy;
        logic signed [16:0] fz;
        logic               in_vol;
    } force_t;

    force_t      expected_force_q[$];
    logic [22:0] len_r;
    logic [22:0] rad_r;
    logic        mode_r;
    logic [15:0] speed_r;
    logic        rev_r;

    // round-half-away of w*c/sqrt(r2): largest n with (2n-1)^2*r2 <= (2wc)^2
    function automatic logic [15:0] vortex_share(logic [15:0] w, longint c, longint r2);
        logic [127:0] two_a;
        logic [127:0] target;
        logic [127:0] lhs;
        logic [16:0]  lo;
        logic [16:0]  hi;
        logic [16:0]  mid;
        logic [33:0]  t;
        two_a = 128'(w) * 128'(c) * 128'd2;
        target = two_a * two_a;
        lo = 0;
        hi = {1'b0, w};
        while (lo < hi)
        begin
            mid = (lo + hi + 17'd1) >> 1;
            t = 34'(mid) * 34'd2 - 34'd1;
            lhs = 128'(t) * 128'(t) * 128'(r2);
            if (lhs <= target)
                lo = mid;
            else
                hi = mid - 17'd1;
        end
        return lo[15:0];
    endfunction

    function automatic logic signed [16:0] with_sign(logic [15:0] mag, logic neg);
        logic signed [16:0] v;
        v = {1'b0, mag};
        return neg ? -v : v;
    endfunction

    function automatic force_t predict_force(logic signed [23:0] px,
                                             logic signed [23:0] py,
                                             logic signed [23:0] pz);
        force_t f;
        longint len;
        longint rad;
        longint x2;
        longint ay;
        longint az;
        longint r2;
        f = '0;
        len = (len_r < MIN_EXTENT) ? longint'(MIN_EXTENT) : longint'(len_r);
        rad = (rad_r < MIN_EXTENT) ? longint'(MIN_EXTENT) : longint'(rad_r);
        x2 = 2 * longint'(px);
        ay = (py < 0) ? -longint'(py) : longint'(py);
        az = (pz < 0) ? -longint'(pz) : longint'(pz);
        r2 = ay * ay + az * az;
        if (x2 <= -len || x2 >= len || r2 >= rad * rad)
            return f;
        f.in_vol = 1'b1;
        if (!mode_r)
            f.fx = with_sign(speed_r, rev_r);
        else if (r2 != 0)
        begin
            f.fy = with_sign(vortex_share(speed_r, az, r2), (pz > 0) != rev_r);
            f.fz = with_sign(vortex_share(speed_r, ay, r2), (py < 0) != rev_r);
        end
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        force_t got;
        force_t want;
        if (!rst_n)
        begin
            expected_force_q.delete();
            len_r = 23'd20480;
            rad_r = 23'd4096;
            mode_r = 1'b0;
            speed_r = 16'd2560;
            rev_r = 1'b0;
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_LENGTH:  len_r = pwdata[22:0];
                    REG_RADIUS:  rad_r = pwdata[22:0];
                    REG_MODE:    mode_r = pwdata[0];
                    REG_SPEED:   speed_r = pwdata[15:0];
                    REG_REVERSE: rev_r = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_force_q.push_back(predict_force(pos_x, pos_y, pos_z));
            if (out_valid && out_ready)
            begin
                got = '{force_x, force_y, force_z, inside_volume};
                if (expected_force_q.size() == 0)
                begin
                    $display("%0t: unexpected result item fx=%0d fy=%0d fz=%0d in=%0b",
                             $time, force_x, force_y, force_z, inside_volume);
                    fail_count++;
                end
                else
                begin
                    want = expected_force_q.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected fx=%0d fy=%0d fz=%0d in=%0b",
                                 $time, want.fx, want.fy, want.fz, want.in_vol);
                        $display("%0t:          actual   fx=%0d fy=%0d fz=%0d in=%0b",
                                 $time, got.fx, got.fy, got.fz, got.in_vol);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_force_q.size();
    end
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Cylinder wind field testbench
// Drives points under several register settings with bursty input and a
// stalling receiver; the checker predicts and compares every force item.
// ============================================================================
module testbench;
    import cwf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 244;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [23:0] pos_x = '0;
    logic signed [23:0] pos_y = '0;
    logic signed [23:0] pos_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [16:0] force_x;
    logic signed [16:0] force_y;
    logic signed [16:0] force_z;
    logic               inside_volume;

    int fail_count;
    int pending;
    int checked;
    int points_sent = 0;
    int settings_used = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    // current geometry, used to aim random points at the volume
    int cur_len = 20480;
    int cur_rad = 4096;

    cylinder_wind_field_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .inside_volume(inside_volume)
    );

    wind_force_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .inside_volume(inside_volume),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: switch among always ready, coin flip, one stall in four,
    // and mostly stalled, each for a random stretch.
    always @(posedge clk or negedge rst_n)
    begin
        static int rdy_mode = 0;
        static int rdy_left = 0;
        static int phase = 0;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rdy_left == 0)
            begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(5, 60);
            end
            rdy_left--;
            phase++;
            case (rdy_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= (phase % 4) != 0;
                default: out_ready <= $urandom_range(0, 7) == 0;
            endcase
        end
    end

    // Watchdog: end the run when no item moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Setup cycle, then access cycle; the write lands on the access edge.
    // psel then drops before the task returns, so the next write starts on a later edge.
    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(int len, int rad, logic mode, int speed, logic rev);
        reg_write(REG_LENGTH, len);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_MODE, mode);
        reg_write(REG_SPEED, speed);
        reg_write(REG_REVERSE, rev);
        cur_len = (len < 410) ? 410 : len;
        cur_rad = (rad < 410) ? 410 : rad;
        settings_used++;
    endtask

    // Hold the point until accepted; drop valid only for a gap between bursts.
    task automatic send_point(int x, int y, int z);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        pos_x <= 24'(x);
        pos_y <= 24'(y);
        pos_z <= 24'(z);
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        points_sent++;
    endtask

    // Drain the pipeline before touching registers.
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (25) @(posedge clk);
    endtask

    function automatic int clamp24(int v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // Random point: mostly near the volume, some on the axis, on the
    // length or radius boundary, or anywhere in the field range.
    task automatic send_random_point();
        int kind;
        int half;
        int x;
        int y;
        int z;
        real rim;
        kind = $urandom_range(0, 9);
        half = cur_len / 2;
        x = clamp24(int'($urandom_range(0, 2 * half + 4)) - half - 2);
        y = clamp24(int'($urandom_range(0, 2 * cur_rad)) - cur_rad);
        z = clamp24(int'($urandom_range(0, 2 * cur_rad)) - cur_rad);
        case (kind)
            0:
            begin
                x = int'($urandom) >>> 8;
                y = int'($urandom) >>> 8;
                z = int'($urandom) >>> 8;
            end
            1:
            begin
                y = 0;
                z = 0;
            end
            2:
            begin
                // length boundary: odd length gives strict test a half step
                x = clamp24(($urandom_range(0, 1) ? half : -half) + $urandom_range(0, 2) - 1);
            end
            3:
            begin
                rim = $sqrt(real'(cur_rad) * cur_rad - real'(y) * y);
                z = clamp24(int'($floor(rim)) + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    z = -z;
            end
            default: ;
        endcase
        send_point(x, y, z);
    endtask

    task automatic send_directed();
        send_point(0, 0, 0);
        send_point(10239, 100, -100);
        send_point(10240, 0, 0);
        send_point(-10239, 0, 50);
        send_point(-10240, 0, 0);
        send_point(0, 4095, 0);
        send_point(0, 4096, 0);
        send_point(0, 0, -4095);
        send_point(0, -4096, 0);
        send_point(0, 2896, 2896);
        send_point(0, -2897, 2896);
        send_point(8388607, 8388607, 8388607);
        send_point(-8388608, -8388608, -8388608);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset settings, then in vortex mode.
        send_directed();
        wait_drained();
        apply_setting(20480, 4096, 1'b1, 2560, 1'b0);
        send_directed();
        wait_drained();

        // Extremes: largest volume and speed, then shortest extents,
        // values below the minimum, zero speed, and reversal.
        apply_setting(8388607, 8388607, 1'b1, 65535, 1'b0);
        repeat (ITEMS_PER_PHASE) send_random_point();
        wait_drained();
        apply_setting(410, 0, 1'b1, 0, 1'b1);
        repeat (ITEMS_PER_PHASE) send_random_point();
        wait_drained();
        apply_setting(0, 410, 1'b0, 65535, 1'b1);
        repeat (ITEMS_PER_PHASE) send_random_point();
        wait_drained();
        apply_setting(8388607, 1000, 1'b1, 1, 1'b1);
        repeat (ITEMS_PER_PHASE) send_random_point();
        wait_drained();

        // Random settings, small extents more often than large ones.
        repeat (4)
        begin
            apply_setting($urandom_range(0, 1) ? $urandom_range(0, 60000)
                                               : $urandom_range(0, 8388607),
                          $urandom_range(0, 1) ? $urandom_range(0, 30000)
                                               : $urandom_range(0, 8388607),
                          $urandom_range(0, 1), $urandom_range(0, 65535),
                          $urandom_range(0, 1));
            repeat (ITEMS_PER_PHASE) send_random_point();
            wait_drained();
        end

        $display("Covered %0d points, %0d results checked, over %0d register settings",
                 points_sent, checked, settings_used + 1);
        $display("with both flow modes, reversal, and minimum and maximum extents.");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
